FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared wrappers for concurrent checks, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

FILE: src/ist_pkg.sv
// ----------------------------------------------------------------------------
// ist_pkg
// shared constants, codes and control structs of the interval set tracker
// ----------------------------------------------------------------------------
package ist_pkg;

   localparam int MAX_INTERVALS_DEF = 16;
   localparam int COORD_BITS_DEF    = 32;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_NONE   = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       init;
      logic       step;
      logic       second;
      logic       tail;
      logic       finish;
      logic [1:0] status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic skip;
      logic empty;
      logic cnt_zero;
      logic p0v;
      logic p1v;
      logic full;
      logic more;
      logic in_range;
      logic tail_need;
   } sts_type;

endpackage

FILE: src/ist_datapath.sv
// ----------------------------------------------------------------------------
// ist_datapath
// double-banked interval tables, scan registers and result register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ist_datapath #(
   parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
   parameter int COORD_BITS    = ist_pkg::COORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [1:0]            op,
   input  logic [COORD_BITS-1:0] lo,
   input  logic [COORD_BITS-1:0] hi,
   input  ist_pkg::cmd_type      cmd,
   output ist_pkg::sts_type      sts,
   output logic                  covered,
   output logic [1:0]            status,
   output logic [4:0]            interval_count
);

   localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CW = $clog2(MAX_INTERVALS + 1);
   localparam int AW = IW + 1;
   localparam int DEPTH = 2 * MAX_INTERVALS;
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

   logic [COORD_BITS-1:0] starts_mem [DEPTH];
   logic [COORD_BITS-1:0] ends_mem   [DEPTH];

   logic [1:0]            op_ff, op_in;
   logic [COORD_BITS-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic                  bank_ff, bank_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         i_ff, i_in, n_ff, n_in;
   logic                  mdone_ff, mdone_in, cov_ff, cov_in;
   logic [COORD_BITS-1:0] ms_ff, ms_in, me_ff, me_in;
   logic [COORD_BITS-1:0] p1s_ff, p1s_in, p1e_ff, p1e_in;
   logic [COORD_BITS-1:0] rd_s_ff, rd_e_ff;
   logic                  cov_out_ff, cov_out_in;
   logic [1:0]            st_out_ff, st_out_in;
   logic [CW-1:0]         cnt_out_ff, cnt_out_in;
   logic [CW+4:0]         cnt_wide;

   logic [AW-1:0]         raddr, waddr;
   logic                  we, commit;
   logic [COORD_BITS-1:0] wd_s, wd_e;
   logic                  p0v, p1v;
   logic [COORD_BITS-1:0] p0s, p0e, p1s, p1e;
   logic [CW:0]           i_next;

   assign raddr  = {bank_ff, i_ff[IW-1:0]};
   assign waddr  = {~bank_ff, n_ff[IW-1:0]};
   assign i_next = {1'b0, i_ff} + {{CW{1'b0}}, 1'b1};

   // per-entry decision: up to two pushes into the spare bank
   always_comb begin
      p0v = 1'b0;
      p1v = 1'b0;
      p0s = rd_s_ff;
      p0e = rd_e_ff;
      p1s = rd_s_ff;
      p1e = rd_e_ff;
      case (op_ff)
         ist_pkg::OP_ADD: begin
            if (mdone_ff) begin
               p0v = 1'b1;
            end else if (rd_e_ff < lo_ff) begin
               p0v = 1'b1;
            end else if (rd_s_ff > hi_ff) begin
               p0v = 1'b1;
               p0s = ms_ff;
               p0e = me_ff;
               p1v = 1'b1;
            end
         end
         ist_pkg::OP_REMOVE: begin
            if (rd_e_ff <= lo_ff || rd_s_ff >= hi_ff) begin
               p0v = 1'b1;
            end else begin
               p0v = (rd_s_ff < lo_ff) || (rd_e_ff > hi_ff);
               p1v = (rd_s_ff < lo_ff) && (rd_e_ff > hi_ff);
               if (rd_s_ff < lo_ff) begin
                  p0e = lo_ff;
               end else begin
                  p0s = hi_ff;
               end
               p1s = hi_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      sts.skip      = (op_ff == ist_pkg::OP_NONE);
      sts.empty     = (lo_ff >= hi_ff);
      sts.cnt_zero  = (count_ff == '0);
      sts.p0v       = p0v;
      sts.p1v       = p1v;
      sts.full      = (n_ff == MAX_CNT);
      sts.more      = (i_next < {1'b0, count_ff});
      sts.in_range  = (i_ff < count_ff);
      sts.tail_need = (op_ff == ist_pkg::OP_ADD) && !mdone_ff;
   end

   always_comb begin
      wd_s = p0s;
      wd_e = p0e;
      if (cmd.second) begin
         wd_s = p1s_ff;
         wd_e = p1e_ff;
      end else if (cmd.tail) begin
         wd_s = ms_ff;
         wd_e = me_ff;
      end
      we = (cmd.step && p0v || cmd.second || cmd.tail && sts.tail_need) && !sts.full;
      commit = cmd.finish && (cmd.status == ist_pkg::ST_OK)
               && (op_ff == ist_pkg::OP_ADD || op_ff == ist_pkg::OP_REMOVE);
   end

   always_comb begin
      op_in    = cmd.capture ? op : op_ff;
      lo_in    = cmd.capture ? lo : lo_ff;
      hi_in    = cmd.capture ? hi : hi_ff;
      i_in     = i_ff;
      n_in     = we ? CW'(n_ff + 1'b1) : n_ff;
      mdone_in = mdone_ff;
      ms_in    = ms_ff;
      me_in    = me_ff;
      cov_in   = cov_ff;
      p1s_in   = p1s_ff;
      p1e_in   = p1e_ff;
      if (cmd.init) begin
         i_in     = '0;
         n_in     = '0;
         mdone_in = 1'b0;
         ms_in    = lo_ff;
         me_in    = hi_ff;
         cov_in   = 1'b0;
      end
      if (cmd.step) begin
         i_in   = i_next[CW-1:0];
         p1s_in = p1s;
         p1e_in = p1e;
         if (op_ff == ist_pkg::OP_QUERY) begin
            cov_in = cov_ff || (rd_s_ff <= lo_ff && rd_e_ff >= hi_ff);
         end
         if (op_ff == ist_pkg::OP_ADD && !mdone_ff && !(rd_e_ff < lo_ff)) begin
            if (rd_s_ff > hi_ff) begin
               mdone_in = 1'b1;
            end else begin
               ms_in = (rd_s_ff < ms_ff) ? rd_s_ff : ms_ff;
               me_in = (rd_e_ff > me_ff) ? rd_e_ff : me_ff;
            end
         end
      end
      bank_in    = commit ? ~bank_ff : bank_ff;
      count_in   = commit ? n_ff : count_ff;
      cov_out_in = cov_out_ff;
      st_out_in  = st_out_ff;
      cnt_out_in = cnt_out_ff;
      if (cmd.finish) begin
         cov_out_in = cov_ff && (op_ff == ist_pkg::OP_QUERY)
                      && (cmd.status == ist_pkg::ST_OK);
         st_out_in  = cmd.status;
         cnt_out_in = count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff  <= 1'b0;
         count_ff <= '0;
         n_ff     <= '0;
      end else begin
         bank_ff  <= bank_in;
         count_ff <= count_in;
         n_ff     <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      i_ff       <= i_in;
      mdone_ff   <= mdone_in;
      ms_ff      <= ms_in;
      me_ff      <= me_in;
      cov_ff     <= cov_in;
      p1s_ff     <= p1s_in;
      p1e_ff     <= p1e_in;
      cov_out_ff <= cov_out_in;
      st_out_ff  <= st_out_in;
      cnt_out_ff <= cnt_out_in;
   end

   // table banks: one read and one write port shared by both banks
   always_ff @(posedge clock) begin
      if (we) begin
         starts_mem[waddr] <= wd_s;
         ends_mem[waddr]   <= wd_e;
      end
      rd_s_ff <= starts_mem[raddr];
      rd_e_ff <= ends_mem[raddr];
   end

   assign cnt_wide       = {5'b0, cnt_out_ff};
   assign covered        = cov_out_ff;
   assign status         = st_out_ff;
   assign interval_count = cnt_wide[4:0];

   `ASSERT_NEVER(a_count_range, clock, reset, count_ff > MAX_CNT)
   `ASSERT_NEVER(a_fill_range, clock, reset, n_ff > MAX_CNT)
   `ASSERT_CLK(a_bank_flip, clock, reset, commit |=> bank_ff != $past(bank_ff))

endmodule

FILE: src/ist_controller.sv
// ----------------------------------------------------------------------------
// ist_controller
// sequencer for the table scan and the result handshake
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ist_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  ist_pkg::sts_type sts,
   output ist_pkg::cmd_type cmd
);

   typedef enum logic [7:0] {
      IDLE  = 8'b0000_0001,
      CHECK = 8'b0000_0010,
      READ  = 8'b0000_0100,
      PROC  = 8'b0000_1000,
      PUSH2 = 8'b0001_0000,
      TAIL  = 8'b0010_0000,
      RESP  = 8'b0100_0000,
      SPARE = 8'b1000_0000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] st_ff, st_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in   = state_ff;
      st_in      = st_ff;
      cmd        = '0;
      cmd.status = st_ff;
      req_tready = (state_ff == IDLE);
      case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = CHECK;
            end
         end
         CHECK: begin
            cmd.init = 1'b1;
            st_in    = ist_pkg::ST_OK;
            if (sts.skip) begin
               state_in = RESP;
            end else if (sts.empty) begin
               st_in    = ist_pkg::ST_EMPTY;
               state_in = RESP;
            end else if (sts.cnt_zero) begin
               state_in = TAIL;
            end else begin
               state_in = READ;
            end
         end
         READ: begin
            state_in = PROC;
         end
         PROC: begin
            cmd.step = 1'b1;
            if (sts.p0v && sts.full) begin
               st_in    = ist_pkg::ST_FULL;
               state_in = RESP;
            end else if (sts.p1v) begin
               state_in = PUSH2;
            end else if (sts.more) begin
               state_in = READ;
            end else begin
               state_in = TAIL;
            end
         end
         PUSH2: begin
            cmd.second = 1'b1;
            if (sts.full) begin
               st_in    = ist_pkg::ST_FULL;
               state_in = RESP;
            end else if (sts.in_range) begin
               state_in = READ;
            end else begin
               state_in = TAIL;
            end
         end
         TAIL: begin
            cmd.tail = 1'b1;
            st_in    = (sts.tail_need && sts.full) ? ist_pkg::ST_FULL : ist_pkg::ST_OK;
            state_in = RESP;
         end
         RESP: begin
            if (!valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
   end

   `ASSERT_CLK(a_accept_check, clock, reset, req_tvalid && req_tready |=> state_ff == CHECK)
   `ASSERT_CLK(a_push2_order, clock, reset, state_ff == PUSH2 |-> $past(state_ff) == PROC)
   `ASSERT_CLK(a_rsp_source, clock, reset, $rose(valid_ff) |-> $past(state_ff) == RESP)

endmodule

FILE: src/interval_set_tracker.sv
// ----------------------------------------------------------------------------
// interval_set_tracker
// sorted set of disjoint half-open intervals with add, remove and query
// ----------------------------------------------------------------------------
// Each request beat carries a span [left, right) and a kind in req_tuser:
// add merges it into the stored set, remove cuts it out (trimming or
// splitting entries), query reports whether one stored interval covers it.
// Every request returns exactly one response beat with the covered flag,
// a status (ok, empty span, table full with the table left unchanged)
// and the interval count afterwards. The block handles one request at a
// time and walks the table one entry at a time through its single read
// port, with an extra write step when an entry splits or the merged
// interval is emitted. Results are built in a second table bank that
// becomes current only on success, so no copy and no clearing pass are
// needed. A finished response waits in an output register while the
// next request is already being taken.
module interval_set_tracker #(
   parameter int MAX_INTERVALS = ist_pkg::MAX_INTERVALS_DEF,
   parameter int COORD_BITS    = ist_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // left_bound, right_bound
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   // req_type
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // covered, interval_count
   output logic [7:0]                            rsp_tdata,
   // status
   output logic [1:0]                            rsp_tuser
);

   ist_pkg::cmd_type cmd;
   ist_pkg::sts_type sts;
   logic             covered;
   logic [4:0]       interval_count;

   // scan sequencer
   ist_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // tables and scan registers
   ist_datapath #(
      .MAX_INTERVALS (MAX_INTERVALS),
      .COORD_BITS    (COORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .op             (req_tuser),
      .lo             (req_tdata[COORD_BITS-1:0]),
      .hi             (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .cmd            (cmd),
      .sts            (sts),
      .covered        (covered),
      .status         (rsp_tuser),
      .interval_count (interval_count)
   );

   assign rsp_tdata = {2'b00, interval_count, covered};

endmodule
